FILE: hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, widths, constant tables and arithmetic helpers of the
// trilinear cell coefficient pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned NUM_STAGES = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned SIZE_W     = 31;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BASE_W     = 40;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned COMB_W     = 34;
  localparam int unsigned RAW_W      = 66;
  localparam int unsigned SUM_W      = 56;
  localparam int unsigned SPLIT      = 28;
  localparam int unsigned LO_W       = SPLIT + 1;
  localparam int unsigned HI_W       = SUM_W - SPLIT;
  localparam int unsigned PL_W       = LO_W + WORD_W;
  localparam int unsigned PH_W       = HI_W + WORD_W;
  localparam int unsigned WIDE_W     = 88;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [BASE_W-1:0] base_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [COMB_W-1:0] comb_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PL_W-1:0]   pl_t;
  typedef logic signed [PH_W-1:0]   ph_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE_X = 3'd0,
    REG_CELL_SIZE_Y = 3'd1,
    REG_CELL_SIZE_Z = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Y    = 3'd4,
    REG_ORIGIN_Z    = 3'd5,
    REG_INV_NEG_VOL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic                  in_ready;
    logic                  out_valid;
  } pipe_ctrl_t;

  // Corner index is x*4 + y*2 + z. Difference n pairs with coordinate product n.
  localparam logic [2:0] D_POS [12] = '{3'd3, 3'd6, 3'd5, 3'd0, 3'd5, 3'd6,
                                        3'd3, 3'd0, 3'd6, 3'd5, 3'd3, 3'd0};
  localparam logic [2:0] D_NEG [12] = '{3'd7, 3'd2, 3'd1, 3'd4, 3'd7, 3'd4,
                                        3'd1, 3'd2, 3'd7, 3'd4, 3'd2, 3'd1};

  // Four-corner combinations; combination n pairs with coordinate n
  // (coordinate index is axis*2 + high).
  localparam logic [2:0] E_P1 [6] = '{3'd4, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2};
  localparam logic [2:0] E_P2 [6] = '{3'd7, 3'd2, 3'd7, 3'd4, 3'd7, 3'd4};
  localparam logic [2:0] E_N1 [6] = '{3'd5, 3'd0, 3'd3, 3'd0, 3'd3, 3'd0};
  localparam logic [2:0] E_N2 [6] = '{3'd6, 3'd3, 3'd6, 3'd5, 3'd5, 3'd6};

  // Coordinate pair products: yz, then xz, then xy, low-low first.
  localparam logic [2:0] P_A [12] = '{3'd2, 3'd2, 3'd3, 3'd3, 3'd0, 3'd0,
                                      3'd1, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1};
  localparam logic [2:0] P_B [12] = '{3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5,
                                      3'd4, 3'd5, 3'd2, 3'd3, 3'd2, 3'd3};

  localparam wide_t SAT_HI = 88'sd2147483647;
  localparam wide_t SAT_LO = -88'sd2147483648;

  // Drop 16 fraction bits, rounding half away from zero.
  function automatic wide_t rnd16(input wide_t p);
    wide_t t;
    t = p + 88'sd32767 + $signed({87'b0, ~p[WIDE_W-1]});
    return t >>> 16;
  endfunction

  function automatic word_t sat32(input wide_t v);
    word_t r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/tcc_intf.sv
// ----------------------------------------------------------------------------
// tcc interfaces
// Input, output and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         cell_i;
  logic [5:0]         cell_j;
  logic [5:0]         cell_k;
  logic signed [31:0] corner_000;
  logic signed [31:0] corner_100;
  logic signed [31:0] corner_010;
  logic signed [31:0] corner_001;
  logic signed [31:0] corner_110;
  logic signed [31:0] corner_101;
  logic signed [31:0] corner_011;
  logic signed [31:0] corner_111;

  modport source (output valid, cell_i, cell_j, cell_k, corner_000, corner_100,
                  corner_010, corner_001, corner_110, corner_101, corner_011,
                  corner_111, input ready);
  modport sink (input valid, cell_i, cell_j, cell_k, corner_000, corner_100,
                corner_010, corner_001, corner_110, corner_101, corner_011,
                corner_111, output ready);
endinterface

interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_const;
  logic signed [31:0] coef_x;
  logic signed [31:0] coef_y;
  logic signed [31:0] coef_z;
  logic signed [31:0] coef_xy;
  logic signed [31:0] coef_xz;
  logic signed [31:0] coef_yz;
  logic signed [31:0] coef_xyz;

  modport source (output valid, coef_const, coef_x, coef_y, coef_z, coef_xy,
                  coef_xz, coef_yz, coef_xyz, input ready);
  modport sink (input valid, coef_const, coef_x, coef_y, coef_z, coef_xy,
                coef_xz, coef_yz, coef_xyz, output ready);
endinterface

interface tcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/tcc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_pipe_ctrl
// Valid bits and per-stage enables of the coefficient pipeline.
// ----------------------------------------------------------------------------
module tcc_pipe_ctrl
  import tcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] en;

  // A stage may load when some stage at or after it holds a bubble.
  always_comb begin
    logic [NUM_STAGES-1:0] low;
    for (int k = 0; k < NUM_STAGES; k++) begin
      low   = (NUM_STAGES'(1) << k) - NUM_STAGES'(1);
      en[k] = out_ready_i | ~&(v_q | low);
    end
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctrl_o.en        = en;
  assign ctrl_o.in_ready  = en[0];
  assign ctrl_o.out_valid = v_q[NUM_STAGES-1];

`ifndef SYNTH
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && en[0]) |=> v_q[0])
    else $error("accepted word did not enter the first stage");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_STAGES-1] && !out_ready_i) |=> v_q[NUM_STAGES-1])
    else $error("stalled result word was lost");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !out_ready_i) |-> !en[0])
    else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule

FILE: hdl/trilinear_cell_coefficients_core.sv
// ----------------------------------------------------------------------------
// trilinear_cell_coefficients_core
// Eight trilinear interpolant coefficients of one grid cell per word.
// ----------------------------------------------------------------------------
// One input word carries a cell's indices and its eight corner values; one
// output word carries the coefficients (constant, x, y, z, xy, xz, yz, xyz),
// each scaled by the inv_neg_volume register and saturated to signed Q16.16.
// The block is a 13-stage pipeline: it accepts one word per cycle unless the
// output is stalled and the pipeline is full. Its stages follow the chain of
// multiplies: corner coordinates, pair products, triple products,
// corner-weighted terms, the sums, and the final 56 by 32 bit scaling, which
// is split into two partial products. Stalls propagate backward only as far
// as the pipeline is full, so bubbles are squeezed out while the output
// waits. Configuration writes are always accepted and take effect at once;
// write them only while no word is in flight.
module trilinear_cell_coefficients_core
  import tcc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  tcc_cfg_if.sink   cfg_i,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  // Configuration registers.
  logic [SIZE_W-1:0] size_q [3];
  word_t             origin_q [3];
  word_t             inv_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        size_q[a]   <= SIZE_W'(65536);
        origin_q[a] <= '0;
      end
      inv_q <= -32'sd65536;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_CELL_SIZE_X: size_q[0]   <= cfg_i.data[SIZE_W-1:0];
        REG_CELL_SIZE_Y: size_q[1]   <= cfg_i.data[SIZE_W-1:0];
        REG_CELL_SIZE_Z: size_q[2]   <= cfg_i.data[SIZE_W-1:0];
        REG_ORIGIN_X:    origin_q[0] <= cfg_i.data;
        REG_ORIGIN_Y:    origin_q[1] <= cfg_i.data;
        REG_ORIGIN_Z:    origin_q[2] <= cfg_i.data;
        REG_INV_NEG_VOL: inv_q       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  pipe_ctrl_t ctrl;

  tcc_pipe_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  assign in_i.ready  = ctrl.in_ready;
  assign out_o.valid = ctrl.out_valid;

  // Input word unpacked by corner index x*4 + y*2 + z.
  word_t            cin [8];
  logic [IDX_W-1:0] idx [3];

  assign cin[0] = in_i.corner_000;
  assign cin[1] = in_i.corner_001;
  assign cin[2] = in_i.corner_010;
  assign cin[3] = in_i.corner_011;
  assign cin[4] = in_i.corner_100;
  assign cin[5] = in_i.corner_101;
  assign cin[6] = in_i.corner_110;
  assign cin[7] = in_i.corner_111;
  assign idx[0] = in_i.cell_i;
  assign idx[1] = in_i.cell_j;
  assign idx[2] = in_i.cell_k;

  // Stage 1: cell base positions, corner differences and combinations.
  base_t base1_d [3], base1_q [3];
  diff_t d1_d [12], d1_q [12];
  comb_t e1_d [6], e1_q [6];
  word_t c1_q [8];

  always_comb begin
    logic [SIZE_W+IDX_W-1:0] prod;
    for (int a = 0; a < 3; a++) begin
      prod       = (SIZE_W+IDX_W)'(idx[a]) * (SIZE_W+IDX_W)'(size_q[a]);
      base1_d[a] = $signed({3'b0, prod}) + BASE_W'(origin_q[a]);
    end
    for (int n = 0; n < 12; n++) begin
      d1_d[n] = DIFF_W'(cin[D_POS[n]]) - DIFF_W'(cin[D_NEG[n]]);
    end
    for (int n = 0; n < 6; n++) begin
      e1_d[n] = COMB_W'(cin[E_P1[n]]) + COMB_W'(cin[E_P2[n]])
              - COMB_W'(cin[E_N1[n]]) - COMB_W'(cin[E_N2[n]]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      base1_q <= base1_d;
      d1_q    <= d1_d;
      e1_q    <= e1_d;
      c1_q    <= cin;
    end
  end

  // Stage 2: saturated low and high corner coordinates per axis.
  word_t co2_d [6], co2_q [6];
  diff_t d2_q [12];
  comb_t e2_q [6];
  word_t c2_q [8];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      co2_d[2*a]   = sat32(WIDE_W'(base1_q[a]));
      co2_d[2*a+1] = sat32(WIDE_W'(base1_q[a] + $signed({9'b0, size_q[a]})));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[1]) begin
      co2_q <= co2_d;
      d2_q  <= d1_q;
      e2_q  <= e1_q;
      c2_q  <= c1_q;
    end
  end

  // Stage 3: raw pair products and single-coordinate terms.
  raw_t  pr3_d [12], pr3_q [12];
  raw_t  er3_d [6], er3_q [6];
  sum_t  s7_3_d, s7_3_q;
  word_t co3_q [6];
  diff_t d3_q [12];
  word_t c3_q [8];

  always_comb begin
    for (int n = 0; n < 12; n++) begin
      pr3_d[n] = RAW_W'(co2_q[P_A[n]]) * RAW_W'(co2_q[P_B[n]]);
    end
    for (int n = 0; n < 6; n++) begin
      er3_d[n] = RAW_W'(e2_q[n]) * RAW_W'(co2_q[n]);
    end
    // The xyz coefficient is minus the sum of the two z combinations.
    s7_3_d = -(SUM_W'(e2_q[4]) + SUM_W'(e2_q[5]));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[2]) begin
      pr3_q  <= pr3_d;
      er3_q  <= er3_d;
      s7_3_q <= s7_3_d;
      co3_q  <= co2_q;
      d3_q   <= d2_q;
      c3_q   <= c2_q;
    end
  end

  // Stage 4: round and saturate the pair products, round the terms.
  word_t pp4_d [12], pp4_q [12];
  sum_t  et4_d [6], et4_q [6];
  sum_t  s7_4_q;
  word_t co4_q [6];
  diff_t d4_q [12];
  word_t c4_q [8];

  always_comb begin
    wide_t r;
    for (int n = 0; n < 12; n++) begin
      pp4_d[n] = sat32(rnd16(WIDE_W'(pr3_q[n])));
    end
    for (int n = 0; n < 6; n++) begin
      r        = rnd16(WIDE_W'(er3_q[n]));
      et4_d[n] = r[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[3]) begin
      pp4_q  <= pp4_d;
      et4_q  <= et4_d;
      s7_4_q <= s7_3_q;
      co4_q  <= co3_q;
      d4_q   <= d3_q;
      c4_q   <= c3_q;
    end
  end

  // Stage 5: raw triple products and difference-weighted pair terms.
  raw_t  tr5_d [8], tr5_q [8];
  raw_t  dr5_d [12], dr5_q [12];
  sum_t  et5_q [6];
  sum_t  s7_5_q;
  word_t c5_q [8];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      tr5_d[n] = RAW_W'(co4_q[n/4]) * RAW_W'(pp4_q[n%4]);
    end
    for (int n = 0; n < 12; n++) begin
      dr5_d[n] = RAW_W'(d4_q[n]) * RAW_W'(pp4_q[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[4]) begin
      tr5_q  <= tr5_d;
      dr5_q  <= dr5_d;
      et5_q  <= et4_q;
      s7_5_q <= s7_4_q;
      c5_q   <= c4_q;
    end
  end

  // Stage 6: round and saturate triples, round pair terms.
  word_t tt6_d [8], tt6_q [8];
  sum_t  dt6_d [12], dt6_q [12];
  sum_t  et6_q [6];
  sum_t  s7_6_q;
  word_t c6_q [8];

  always_comb begin
    wide_t r;
    for (int n = 0; n < 8; n++) begin
      tt6_d[n] = sat32(rnd16(WIDE_W'(tr5_q[n])));
    end
    for (int n = 0; n < 12; n++) begin
      r        = rnd16(WIDE_W'(dr5_q[n]));
      dt6_d[n] = r[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[5]) begin
      tt6_q  <= tt6_d;
      dt6_q  <= dt6_d;
      et6_q  <= et5_q;
      s7_6_q <= s7_5_q;
      c6_q   <= c5_q;
    end
  end

  // Stage 7: corner times opposite triple; sums of the x..xyz coefficients.
  raw_t cr7_d [8], cr7_q [8];
  sum_t sm7_d [7], sm7_q [7];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      cr7_d[n] = RAW_W'(c6_q[n]) * RAW_W'(tt6_q[7-n]);
    end
    for (int g = 0; g < 3; g++) begin
      sm7_d[g] = dt6_q[4*g] + dt6_q[4*g+1] + dt6_q[4*g+2] + dt6_q[4*g+3];
    end
    sm7_d[3] = et6_q[4] + et6_q[5];
    sm7_d[4] = et6_q[2] + et6_q[3];
    sm7_d[5] = et6_q[0] + et6_q[1];
    sm7_d[6] = s7_6_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[6]) begin
      cr7_q <= cr7_d;
      sm7_q <= sm7_d;
    end
  end

  // Stage 8: round the constant-term products; a corner with an odd number
  // of high offsets adds, the others subtract.
  sum_t ct8_d [8], ct8_q [8];
  sum_t sm8_q [7];

  always_comb begin
    wide_t r;
    for (int n = 0; n < 8; n++) begin
      r = rnd16(WIDE_W'(cr7_q[n]));
      if (^3'(n)) begin
        ct8_d[n] = r[SUM_W-1:0];
      end else begin
        ct8_d[n] = -r[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[7]) begin
      ct8_q <= ct8_d;
      sm8_q <= sm7_q;
    end
  end

  // Stage 9: two half sums of the constant term.
  sum_t s0a9_q, s0b9_q;
  sum_t sm9_q [7];

  always_ff @(posedge clk_i) begin
    if (ctrl.en[8]) begin
      s0a9_q <= ct8_q[0] + ct8_q[1] + ct8_q[2] + ct8_q[3];
      s0b9_q <= ct8_q[4] + ct8_q[5] + ct8_q[6] + ct8_q[7];
      sm9_q  <= sm8_q;
    end
  end

  // Stage 10: all eight exact sums.
  sum_t sv10_d [8], sv10_q [8];

  always_comb begin
    sv10_d[0] = s0a9_q + s0b9_q;
    for (int n = 1; n < 8; n++) begin
      sv10_d[n] = sm9_q[n-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[9]) begin
      sv10_q <= sv10_d;
    end
  end

  // Stage 11: scaling by inv_neg_volume, split into high and low halves.
  pl_t pl11_d [8], pl11_q [8];
  ph_t ph11_d [8], ph11_q [8];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      pl11_d[n] = PL_W'($signed({1'b0, sv10_q[n][SPLIT-1:0]})) * PL_W'(inv_q);
      ph11_d[n] = PH_W'($signed(sv10_q[n][SUM_W-1:SPLIT])) * PH_W'(inv_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[10]) begin
      pl11_q <= pl11_d;
      ph11_q <= ph11_d;
    end
  end

  // Stage 12: recombine the partial products.
  wide_t p12_q [8];

  always_ff @(posedge clk_i) begin
    if (ctrl.en[11]) begin
      for (int n = 0; n < 8; n++) begin
        p12_q[n] <= (WIDE_W'(ph11_q[n]) <<< SPLIT) + WIDE_W'(pl11_q[n]);
      end
    end
  end

  // Stage 13: round, saturate and hold the output word.
  word_t out13_q [8];

  always_ff @(posedge clk_i) begin
    if (ctrl.en[12]) begin
      for (int n = 0; n < 8; n++) begin
        out13_q[n] <= sat32(rnd16(p12_q[n]));
      end
    end
  end

  assign out_o.coef_const = out13_q[0];
  assign out_o.coef_x     = out13_q[1];
  assign out_o.coef_y     = out13_q[2];
  assign out_o.coef_z     = out13_q[3];
  assign out_o.coef_xy    = out13_q[4];
  assign out_o.coef_xz    = out13_q[5];
  assign out_o.coef_yz    = out13_q[6];
  assign out_o.coef_xyz   = out13_q[7];

endmodule

FILE: verif/trilinear_cell_coefficients_core_test.sv
// ----------------------------------------------------------------------------
// trilinear_cell_coefficients_core_test
// Self-checking testbench of the trilinear cell coefficient pipeline.
// ----------------------------------------------------------------------------
// Each cell word sent to the block is run through a predictor of the eight
// interpolant coefficients, and the expected word is queued. Output words are
// compared field by field with the oldest queued expectation. The run walks
// through several register settings, the reset values and the extremes among
// them, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module trilinear_cell_coefficients_core_test;
  import tcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned ITEMS_PER_SET = 240;
  localparam int unsigned DRAIN_CYCLES  = NUM_STAGES + 8;
  // The block has no register at this index; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Corner order: 000, 100, 010, 001, 110, 101, 011, 111.
  typedef struct {
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] cj;
    logic [IDX_W-1:0] ck;
    word_t            corner [8];
  } cell_t;

  // Coefficient order: const, x, y, z, xy, xz, yz, xyz.
  typedef struct {
    word_t coef [8];
  } coefs_t;

  // Holds a copy of the register file, predicts the coefficients of every
  // accepted cell word and checks the output words against them.
  class coef_scoreboard;
    longint size_x, size_y, size_z;
    longint org_x, org_y, org_z, inv_vol;
    coefs_t pending_coefs [$];
    int     errors;
    int     checked;

    function new();
      size_x  = 65536;
      size_y  = 65536;
      size_z  = 65536;
      org_x   = 0;
      org_y   = 0;
      org_z   = 0;
      inv_vol = -65536;
      errors  = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_CELL_SIZE_X: size_x  = longint'({1'b0, val[30:0]});
        REG_CELL_SIZE_Y: size_y  = longint'({1'b0, val[30:0]});
        REG_CELL_SIZE_Z: size_z  = longint'({1'b0, val[30:0]});
        REG_ORIGIN_X:    org_x   = longint'(signed'(val));
        REG_ORIGIN_Y:    org_y   = longint'(signed'(val));
        REG_ORIGIN_Z:    org_z   = longint'(signed'(val));
        REG_INV_NEG_VOL: inv_vol = longint'(signed'(val));
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q16.16 product, rounded half away from zero, magnitude limited to 2^62.
    function longint qmul(longint a, longint b);
      logic [127:0] ua, ub, p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = (ua * ub + 128'h8000) >> 16;
      if (p > (128'd1 << 62)) p = 128'd1 << 62;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void note(cell_t c);
      longint bx, by, bz, x0, x1, y0, y1, z0, z1;
      longint c000, c100, c010, c001, c110, c101, c011, c111;
      longint y0z0, y0z1, y1z0, y1z1, x0z0, x0z1, x1z0, x1z1;
      longint x0y0, x0y1, x1y0, x1y1;
      longint t000, t001, t010, t011, t100, t101, t110, t111;
      longint s [8];
      coefs_t r;
      bx = longint'(c.ci) * size_x + org_x;
      by = longint'(c.cj) * size_y + org_y;
      bz = longint'(c.ck) * size_z + org_z;
      x0 = clamp32(bx);
      x1 = clamp32(bx + size_x);
      y0 = clamp32(by);
      y1 = clamp32(by + size_y);
      z0 = clamp32(bz);
      z1 = clamp32(bz + size_z);
      c000 = c.corner[0];
      c100 = c.corner[1];
      c010 = c.corner[2];
      c001 = c.corner[3];
      c110 = c.corner[4];
      c101 = c.corner[5];
      c011 = c.corner[6];
      c111 = c.corner[7];
      y0z0 = clamp32(qmul(y0, z0));
      y0z1 = clamp32(qmul(y0, z1));
      y1z0 = clamp32(qmul(y1, z0));
      y1z1 = clamp32(qmul(y1, z1));
      x0z0 = clamp32(qmul(x0, z0));
      x0z1 = clamp32(qmul(x0, z1));
      x1z0 = clamp32(qmul(x1, z0));
      x1z1 = clamp32(qmul(x1, z1));
      x0y0 = clamp32(qmul(x0, y0));
      x0y1 = clamp32(qmul(x0, y1));
      x1y0 = clamp32(qmul(x1, y0));
      x1y1 = clamp32(qmul(x1, y1));
      t000 = clamp32(qmul(x0, y0z0));
      t001 = clamp32(qmul(x0, y0z1));
      t010 = clamp32(qmul(x0, y1z0));
      t011 = clamp32(qmul(x0, y1z1));
      t100 = clamp32(qmul(x1, y0z0));
      t101 = clamp32(qmul(x1, y0z1));
      t110 = clamp32(qmul(x1, y1z0));
      t111 = clamp32(qmul(x1, y1z1));
      s[0] = -qmul(c000, t111) + qmul(c001, t110) + qmul(c010, t101) - qmul(c011, t100)
             + qmul(c100, t011) - qmul(c101, t010) - qmul(c110, t001) + qmul(c111, t000);
      s[1] = qmul(c000 - c100, y1z1) + qmul(c101 - c001, y1z0)
             + qmul(c110 - c010, y0z1) + qmul(c011 - c111, y0z0);
      s[2] = qmul(c000 - c010, x1z1) + qmul(c011 - c001, x1z0)
             + qmul(c110 - c100, x0z1) + qmul(c101 - c111, x0z0);
      s[3] = qmul(c000 - c001, x1y1) + qmul(c011 - c010, x1y0)
             + qmul(c101 - c100, x0y1) + qmul(c110 - c111, x0y0);
      s[4] = qmul(-c000 + c010 + c100 - c110, z1) + qmul(c001 - c011 - c101 + c111, z0);
      s[5] = qmul(-c000 + c001 + c100 - c101, y1) + qmul(c010 - c011 - c110 + c111, y0);
      s[6] = qmul(-c000 + c001 + c010 - c011, x1) + qmul(c100 - c101 - c110 + c111, x0);
      s[7] = c000 - c001 - c010 + c011 - c100 + c101 + c110 - c111;
      for (int n = 0; n < 8; n++) begin
        r.coef[n] = word_t'(clamp32(qmul(s[n], inv_vol)));
      end
      pending_coefs.push_back(r);
    endfunction

    function void check(coefs_t got);
      string  names [8] = '{"coef_const", "coef_x", "coef_y", "coef_z",
                            "coef_xy", "coef_xz", "coef_yz", "coef_xyz"};
      coefs_t want;
      if (pending_coefs.size() == 0) begin
        report("output word with no expected word waiting");
        return;
      end
      want = pending_coefs.pop_front();
      checked++;
      for (int n = 0; n < 8; n++) begin
        if (got.coef[n] !== want.coef[n]) begin
          report($sformatf("word %0d %s got %h expected %h", checked, names[n],
                           got.coef[n], want.coef[n]));
        end
      end
    endfunction

    function int pending();
      return pending_coefs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  longint unsigned cycles;
  bit quiet_input;
  coef_scoreboard sb;

  tcc_cfg_if cfg_if ();
  tcc_in_if  in_if ();
  tcc_out_if out_if ();

  trilinear_cell_coefficients_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: the ready line toggles between bursts and stalls of random length.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int g;
      @(negedge clk_i);
      out_if.ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_if.ready = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // Output monitor: every accepted word is checked at the rising edge.
  initial begin
    coefs_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.coef[0] = out_if.coef_const;
        got.coef[1] = out_if.coef_x;
        got.coef[2] = out_if.coef_y;
        got.coef[3] = out_if.coef_z;
        got.coef[4] = out_if.coef_xy;
        got.coef[5] = out_if.coef_xz;
        got.coef[6] = out_if.coef_yz;
        got.coef[7] = out_if.coef_xyz;
        sb.check(got);
      end
    end
  end

  // Sends one cell word; called at a falling edge and returns at one.
  task automatic send_cell(cell_t c);
    int g;
    g = quiet_input ? 0 : pick_gap();
    if (g > 0) begin
      in_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.cell_i     = c.ci;
    in_if.cell_j     = c.cj;
    in_if.cell_k     = c.ck;
    in_if.corner_000 = c.corner[0];
    in_if.corner_100 = c.corner[1];
    in_if.corner_010 = c.corner[2];
    in_if.corner_001 = c.corner[3];
    in_if.corner_110 = c.corner[4];
    in_if.corner_101 = c.corner[5];
    in_if.corner_011 = c.corner[6];
    in_if.corner_111 = c.corner[7];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(c);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.configure(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Registers change only once the pipeline has drained.
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] inv);
    write_reg(REG_CELL_SIZE_X, sx);
    write_reg(REG_CELL_SIZE_Y, sy);
    write_reg(REG_CELL_SIZE_Z, sz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_NEG_VOL, inv);
  endtask

  function automatic word_t rand_corner();
    case ($urandom_range(0, 3))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sh1;
        endcase
      end
      default: return word_t'($urandom) >>> $urandom_range(4, 24);
    endcase
  endfunction

  task automatic send_random(int n);
    cell_t c;
    for (int k = 0; k < n; k++) begin
      // Runs of back-to-back words alternate with gappy stretches.
      if ((k % 50) == 0) quiet_input = ($urandom_range(0, 3) == 0);
      c.ci = $urandom_range(0, 63);
      c.cj = $urandom_range(0, 63);
      c.ck = $urandom_range(0, 63);
      for (int m = 0; m < 8; m++) c.corner[m] = rand_corner();
      send_cell(c);
    end
    quiet_input = 1'b0;
  endtask

  // Extreme corner patterns and the grid indices at both ends.
  task automatic send_directed();
    cell_t c;
    for (int p = 0; p < 20; p++) begin
      case (p % 5)
        0: c.ci = 0;
        1: c.ci = 62;
        2: c.ci = 63;
        3: c.ci = 31;
        default: c.ci = 1;
      endcase
      c.cj = (p % 3 == 0) ? 6'd63 : 6'(p);
      c.ck = (p % 4 == 0) ? 6'd0 : 6'(62 - p);
      for (int m = 0; m < 8; m++) begin
        case (p % 5)
          0: c.corner[m] = 32'sh7FFF_FFFF;
          1: c.corner[m] = 32'sh8000_0000;
          2: c.corner[m] = 32'sh0;
          3: c.corner[m] = (m % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: c.corner[m] = (m == p % 8) ? 32'sh0001_0000 : 32'sh0;
        endcase
      end
      send_cell(c);
    end
  endtask

  initial begin
    sb           = new();
    cycles       = 0;
    quiet_input  = 1'b0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CELL_SIZE_X;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.cell_i = '0;
    in_if.cell_j = '0;
    in_if.cell_k = '0;
    in_if.corner_000 = '0;
    in_if.corner_100 = '0;
    in_if.corner_010 = '0;
    in_if.corner_001 = '0;
    in_if.corner_110 = '0;
    in_if.corner_101 = '0;
    in_if.corner_011 = '0;
    in_if.corner_111 = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values first, with the directed patterns.
    send_directed();
    send_random(ITEMS_PER_SET);

    // Smallest cells; a write to the unused index must not disturb anything.
    wait_idle();
    write_all(32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_random(ITEMS_PER_SET);

    // Largest cells and origin: corner coordinates saturate.
    wait_idle();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_directed();
    send_random(ITEMS_PER_SET);

    // Zero cell size (the top data bit is dropped), lowest origin.
    wait_idle();
    write_all(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF);
    send_random(ITEMS_PER_SET);

    // Realistic grids with random scaling that does not match the volume.
    for (int s = 0; s < 3; s++) begin
      wait_idle();
      write_all($urandom_range(1, 32'h3_0000), $urandom_range(1, 32'h3_0000),
                $urandom_range(1, 32'h3_0000),
                $urandom_range(0, 32'h20_0000) - 32'h10_0000,
                $urandom_range(0, 32'h20_0000) - 32'h10_0000,
                $urandom_range(0, 32'h20_0000) - 32'h10_0000, $urandom);
      send_random(ITEMS_PER_SET);
    end

    // Every register bit at random.
    wait_idle();
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_random(ITEMS_PER_SET);

    wait_idle();
    $display("Checked %0d coefficient words over eight register settings,", sb.checked);
    $display("including reset values, saturating grids and zero-size cells.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tcc_pkg.sv
hdl/tcc_intf.sv
hdl/tcc_pipe_ctrl.sv
hdl/trilinear_cell_coefficients_core.sv
verif/trilinear_cell_coefficients_core_test.sv
